/* rtl/adp_pkg.sv */
// adp_pkg: shared types, constants and codes for the audio downmix packetizer.
// Used by adp_front, adp_queue, adp_back and the top level.
// No dependencies.
package adp_pkg;

    localparam int ADP_CHAN_W             = 32;
    localparam int ADP_NUM_IN_CHANNELS    = 8;
    localparam int ADP_MAX_CHANNELS       = 8;
    localparam int ADP_SAMPLES_PER_PACKET = 256;
    localparam int ADP_QUEUE_DEPTH        = 2;

    // accumulator: up to 8 x (2^31 - 1) plus sign
    localparam int ADP_ACC_W    = 36;
    localparam int ADP_DIV_BITS = 4;
    localparam int ADP_DIV_STEPS = ADP_ACC_W / ADP_DIV_BITS;
    localparam int ADP_PROD_W   = 40;

    localparam logic [ADP_ACC_W-1:0] ADP_FIX_ONE = ADP_ACC_W'(64'h100_0000);
    localparam logic [14:0]          ADP_SCALE   = 15'd32767;

    localparam logic [1:0] FMT_INT16   = 2'd0;
    localparam logic [1:0] FMT_FLOAT32 = 2'd1;

    typedef enum logic [1:0] {
        REG_CHANNEL_COUNT = 2'd0,
        REG_SAMPLE_FORMAT = 2'd1,
        REG_SAMPLE_RATE   = 2'd2,
        REG_ENABLED       = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        K_ZERO  = 2'd0,
        K_INT   = 2'd1,
        K_FLOAT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        BK_IDLE   = 3'd0,
        BK_ACCUM  = 3'd1,
        BK_PREP   = 3'd2,
        BK_DIVIDE = 3'd3,
        BK_SCALE  = 3'd4,
        BK_OUT    = 3'd5
    } t_back_state;

    typedef struct packed {
        logic [31:0] chan0;
        logic [31:0] chan1;
        logic [31:0] chan2;
        logic [31:0] chan3;
        logic [31:0] chan4;
        logic [31:0] chan5;
        logic [31:0] chan6;
        logic [31:0] chan7;
        logic        silent;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] mono_sample;
        logic [15:0]        packet_number;
        logic [7:0]         slot;
        logic               last;
        logic [15:0]        rate_out;
    } t_out_item;

    // classified job handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  n;
        logic [15:0] packet_number;
        logic [7:0]  slot;
        logic        last;
        logic [15:0] rate;
    } t_job_hdr;

endpackage

/* rtl/adp_front.sv */
// adp_front: config registers, frame accept, classification and packet tagging.
// Depends on adp_pkg.
module adp_front
    import adp_pkg::*;
#(
    parameter int MAX_CHANNELS = ADP_MAX_CHANNELS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [15:0]                        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  t_in_item                           i_in_item,
    input  logic                               i_q_full,
    output logic                               o_push,
    output t_job_hdr                           o_push_hdr,
    output logic [MAX_CHANNELS*ADP_CHAN_W-1:0] o_push_chans
);

    logic [3:0]  r_channel_count;
    logic [1:0]  r_sample_format;
    logic [15:0] r_sample_rate;
    logic        r_enabled;
    logic [7:0]  r_fill;
    logic [15:0] r_pkt_seq;
    logic [7:0]  n_fill;
    logic [15:0] n_pkt_seq;

    logic        accept;
    logic        last;
    logic [3:0]  n_eff;
    t_kind       kind;
    logic [ADP_NUM_IN_CHANNELS*ADP_CHAN_W-1:0] all_chans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 4'd2;
            r_sample_format <= FMT_FLOAT32;
            r_sample_rate   <= 16'd48000;
            r_enabled       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[3:0];
                REG_SAMPLE_FORMAT: r_sample_format <= i_cfg_data[1:0];
                REG_SAMPLE_RATE:   r_sample_rate   <= i_cfg_data;
                REG_ENABLED:       r_enabled       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // dropped frames are taken at once; converted ones wait for queue room
    assign o_in_stall = r_enabled & i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = accept & r_enabled;

    assign last = ({1'b0, r_fill} + 9'd1) >= 9'(ADP_SAMPLES_PER_PACKET);

    always_comb begin
        if (r_channel_count == 4'd0) begin
            n_eff = 4'd1;
        end else if (r_channel_count > 4'(MAX_CHANNELS)) begin
            n_eff = 4'(MAX_CHANNELS);
        end else begin
            n_eff = r_channel_count;
        end
    end

    always_comb begin
        if (i_in_item.silent) begin
            kind = K_ZERO;
        end else begin
            case (r_sample_format)
                FMT_INT16:   kind = K_INT;
                FMT_FLOAT32: kind = K_FLOAT;
                default:     kind = K_ZERO;
            endcase
        end
    end

    always_comb begin
        o_push_hdr.kind          = kind;
        o_push_hdr.n             = n_eff;
        o_push_hdr.packet_number = r_pkt_seq;
        o_push_hdr.slot          = r_fill;
        o_push_hdr.last          = last;
        o_push_hdr.rate          = r_sample_rate;
    end

    // channel 0 in the low word
    assign all_chans = {i_in_item.chan7, i_in_item.chan6, i_in_item.chan5, i_in_item.chan4,
                        i_in_item.chan3, i_in_item.chan2, i_in_item.chan1, i_in_item.chan0};
    assign o_push_chans = all_chans[MAX_CHANNELS*ADP_CHAN_W-1:0];

    always_comb begin
        n_fill    = r_fill;
        n_pkt_seq = r_pkt_seq;
        if (o_push) begin
            if (last) begin
                n_fill    = 8'd0;
                n_pkt_seq = r_pkt_seq + 16'd1;
            end else begin
                n_fill = r_fill + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= 8'd0;
            r_pkt_seq <= 16'd0;
        end else begin
            r_fill    <= n_fill;
            r_pkt_seq <= n_pkt_seq;
        end
    end

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_fill} < 9'(ADP_SAMPLES_PER_PACKET))
        else $error("fill count past packet length");
    a_drop_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !r_enabled) |-> (!o_in_stall && !o_push))
        else $error("disabled frame not dropped");
`endif

endmodule

/* rtl/adp_queue.sv */
// adp_queue: small FIFO of classified jobs between front and back.
// Depends on adp_pkg.
module adp_queue
    import adp_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = ADP_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");
`endif

endmodule

/* rtl/adp_back.sv */
// adp_back: per-job channel conversion, accumulate, serial divide, scale, output register.
// Depends on adp_pkg.
module adp_back
    import adp_pkg::*;
#(
    parameter int MAX_CHANNELS = ADP_MAX_CHANNELS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  t_job_hdr                           i_q_hdr,
    input  logic [MAX_CHANNELS*ADP_CHAN_W-1:0] i_q_chans,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output t_out_item                          o_out_item
);

    localparam int STEP_W = $clog2(ADP_DIV_STEPS);

    t_back_state r_state, n_state;

    logic [MAX_CHANNELS*ADP_CHAN_W-1:0] r_chan, n_chan;
    t_job_hdr                 r_hdr, n_hdr;
    logic [3:0]               r_cnt, n_cnt;
    logic signed [ADP_ACC_W-1:0] r_acc, n_acc;
    logic                     r_sign, n_sign;
    logic [ADP_ACC_W-1:0]     r_quo, n_quo;
    logic [3:0]               r_rem, n_rem;
    logic [STEP_W-1:0]        r_step, n_step;
    logic [ADP_PROD_W-1:0]    r_prod, n_prod;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out_item, n_out_item;

    logic                     out_free;

    // float32 bits to signed Q7.24, saturating, NaN and denormals to zero
    function automatic logic signed [31:0] fix_of(input logic [31:0] bits);
        logic [7:0]  expo;
        logic [23:0] full;
        logic [7:0]  sh;
        logic [30:0] mag;
        expo = bits[30:23];
        full = {1'b1, bits[22:0]};
        sh   = 8'd0;
        mag  = '0;
        if (expo == 8'hFF) begin
            mag = (bits[22:0] != '0) ? 31'd0 : 31'h7FFF_FFFF;
        end else if (expo == 8'd0) begin
            mag = 31'd0;
        end else if (expo >= 8'd126) begin
            sh  = expo - 8'd126;
            mag = (sh >= 8'd8) ? 31'h7FFF_FFFF : (31'(full) << sh[2:0]);
        end else begin
            sh  = 8'd126 - expo;
            mag = (sh >= 8'd24) ? 31'd0 : 31'(full >> sh[4:0]);
        end
        fix_of = bits[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign o_pop       = (r_state == BK_IDLE) & i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin : next_state_logic
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_hdr.kind == K_ZERO) ? BK_OUT : BK_ACCUM;
                end
            end
            BK_ACCUM:  if (r_cnt == 4'd1) n_state = BK_PREP;
            BK_PREP:   n_state = BK_DIVIDE;
            BK_DIVIDE: if (r_step == STEP_W'(ADP_DIV_STEPS - 1)) n_state = BK_SCALE;
            BK_SCALE:  n_state = BK_OUT;
            BK_OUT:    if (out_free) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    always_comb begin : datapath_logic
        logic signed [31:0] conv;
        logic [3:0]           rem_v;
        logic [4:0]           trial;
        logic [ADP_ACC_W-1:0] quo_v;
        logic [24:0]          clamp;
        logic [16:0]          mag17;
        logic [16:0]          res17;

        n_chan      = r_chan;
        n_hdr       = r_hdr;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_sign      = r_sign;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_step      = r_step;
        n_prod      = r_prod;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_item  = r_out_item;

        conv  = (r_hdr.kind == K_FLOAT) ? fix_of(r_chan[ADP_CHAN_W-1:0])
                                        : 32'($signed(r_chan[15:0]));
        rem_v = r_rem;
        quo_v = r_quo;
        trial = '0;
        clamp = (r_quo > ADP_FIX_ONE) ? ADP_FIX_ONE[24:0] : r_quo[24:0];
        mag17 = (r_hdr.kind == K_FLOAT) ? {1'b0, r_prod[ADP_PROD_W-1:24]} : r_quo[16:0];
        res17 = r_sign ? (17'd0 - mag17) : mag17;

        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_chan = i_q_chans;
                    n_hdr  = i_q_hdr;
                    n_cnt  = i_q_hdr.n;
                    n_acc  = '0;
                    n_sign = 1'b0;
                    n_quo  = '0;
                end
            end
            BK_ACCUM: begin
                n_acc  = r_acc + ADP_ACC_W'(conv);
                n_chan = r_chan >> ADP_CHAN_W;
                n_cnt  = r_cnt - 4'd1;
            end
            BK_PREP: begin
                n_sign = r_acc[ADP_ACC_W-1];
                n_quo  = r_acc[ADP_ACC_W-1] ? ADP_ACC_W'(-r_acc) : ADP_ACC_W'(r_acc);
                n_rem  = 4'd0;
                n_step = '0;
            end
            BK_DIVIDE: begin
                // restoring division, several quotient bits per cycle
                for (int j = 0; j < ADP_DIV_BITS; j++) begin
                    trial = {rem_v, quo_v[ADP_ACC_W-1]};
                    quo_v = {quo_v[ADP_ACC_W-2:0], 1'b0};
                    if (trial >= {1'b0, r_hdr.n}) begin
                        trial    = trial - {1'b0, r_hdr.n};
                        quo_v[0] = 1'b1;
                    end
                    rem_v = trial[3:0];
                end
                n_quo  = quo_v;
                n_rem  = rem_v;
                n_step = r_step + 1'b1;
            end
            BK_SCALE: begin
                n_prod = ADP_PROD_W'(clamp) * ADP_PROD_W'(ADP_SCALE);
            end
            BK_OUT: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_item.mono_sample     = $signed(res17[15:0]);
                    n_out_item.packet_number   = r_hdr.packet_number;
                    n_out_item.slot            = r_hdr.slot;
                    n_out_item.last            = r_hdr.last;
                    n_out_item.rate_out        = r_hdr.rate;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan     <= n_chan;
        r_hdr      <= n_hdr;
        r_cnt      <= n_cnt;
        r_acc      <= n_acc;
        r_sign     <= n_sign;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_prod     <= n_prod;
        r_out_item <= n_out_item;
    end

`ifndef SYNTHESIS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIVIDE) |-> (r_rem < r_hdr.n))
        else $error("divider remainder not below channel count");
    a_float_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_OUT && r_hdr.kind == K_FLOAT) |->
        (r_prod[ADP_PROD_W-1:24] <= 16'd32767))
        else $error("scaled float sample out of range");
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_OUT && n_state == BK_IDLE) |=> r_out_valid)
        else $error("result lost leaving output state");
`endif

endmodule

/* rtl/audio_downmix_packetizer.sv */
// audio_downmix_packetizer: top level, multichannel frame to tagged mono sample.
// Depends on adp_pkg, adp_front, adp_queue, adp_back.
//
//   channel   direction  handshake               payload
//   -------   ---------  ----------------------  -----------------------------
//   cfg       in         i_cfg_we                i_cfg_index, i_cfg_data
//   in        in         i_in_valid/o_in_stall   i_in_item   (t_in_item)
//   out       out        o_out_valid/i_out_stall o_out_item  (t_out_item)
//
// A converted frame runs the back end's accumulate state once per channel in use, then
// prepare, divide, scale and output; silent or unsupported-format frames go straight to
// output. The back end is one shared accumulator followed by a 4-bit-per-cycle divider.
// Reset is synchronous, active low, and restores the register defaults and zero
// tagging state. The front stalls only when the job queue is full; disabled
// frames are always taken and dropped. The output register lets the back end
// start its next job while a result waits out a downstream stall.
module audio_downmix_packetizer
    import adp_pkg::*;
#(
    parameter int MAX_CHANNELS = ADP_MAX_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    localparam int CHANS_W = MAX_CHANNELS * ADP_CHAN_W;
    localparam int JOB_W   = $bits(t_job_hdr) + CHANS_W;

    // front -> queue
    logic               push;
    t_job_hdr           push_hdr;
    logic [CHANS_W-1:0] push_chans;
    logic               q_full;

    // queue -> back
    logic               q_valid;
    logic               pop;
    logic [JOB_W-1:0]   q_data;
    t_job_hdr           q_hdr;
    logic [CHANS_W-1:0] q_chans;

    adp_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_hdr   (push_hdr),
        .o_push_chans (push_chans)
    );

    adp_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (ADP_QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_hdr, push_chans}),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    assign q_hdr   = t_job_hdr'(q_data[JOB_W-1:CHANS_W]);
    assign q_chans = q_data[CHANS_W-1:0];

    adp_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_hdr     (q_hdr),
        .i_q_chans   (q_chans),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

/* bench/tb_audio_downmix_packetizer.sv */
// Self-checking testbench for audio_downmix_packetizer: random and directed frames,
// bit-exact prediction of every tagged mono sample. Depends on adp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_audio_downmix_packetizer;
    import adp_pkg::*;

    // sample_format codes that the package leaves unnamed: both give zero samples
    localparam logic [1:0] FMT_UNSUPPORTED = 2'd2;
    localparam logic [1:0] FMT_RESERVED    = 2'd3;

    localparam longint FIX_ONE = 64'sd16777216;   // 1.0 with 24 fraction bits
    localparam longint FIX_SAT = 64'sd2147483647;

    localparam int SETTLE_CYCLES  = 64;    // well past the worst back-end job
    localparam int DRAIN_LIMIT    = 20000;
    localparam int HOLD_CYCLES    = 300;   // long downstream hold-off
    localparam int PHASES         = 14;
    localparam int FRAMES_ENABLED = 150;
    localparam int FRAMES_DROPPED = 30;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = REG_CHANNEL_COUNT;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_item   = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;

    audio_downmix_packetizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the registers and the tag counters.
    // Registers only change while nothing is in flight, so the copy is
    // updated at the write itself.
    // ------------------------------------------------------------------
    logic [3:0]  cfg_chan_count = 4'd2;
    logic [1:0]  cfg_format     = FMT_FLOAT32;
    logic [15:0] cfg_rate       = 16'd48000;
    logic        cfg_enabled    = 1'b1;
    logic [7:0]  slot_fill      = '0;
    logic [15:0] packet_seq     = '0;

    t_in_item  pending_frames[$];     // frames waiting for the driver
    t_out_item expected_samples[$];   // predicted results, oldest first
    int        frames_taken = 0;      // accepted input transfers
    int        errors       = 0;

    // append a frame behind the ones already waiting for the driver
    task automatic add_frame(t_in_item f);
        pending_frames.insert(pending_frames.size(), f);
    endtask

    // float32 bits to signed 8.24 fixed point, truncating toward zero
    function automatic longint fix24_of(logic [31:0] bits);
        int     ex;
        longint full;
        longint mag;
        ex   = int'(bits[30:23]);
        full = longint'({1'b1, bits[22:0]});
        if (ex == 255) begin
            if (bits[22:0] != '0) return 0;    // NaN reads as zero
            mag = FIX_SAT;
        end else if (ex == 0) begin
            mag = 0;                           // zero and denormals
        end else if (ex >= 126) begin
            mag = (ex - 126 >= 8) ? FIX_SAT : (full << (ex - 126));
        end else begin
            mag = (126 - ex >= 24) ? 0 : (full >> (126 - ex));
        end
        return bits[31] ? -mag : mag;
    endfunction

    // Work out the tagged sample for one accepted frame and advance the tags.
    task automatic predict_sample(t_in_item f);
        logic [31:0] ch [8];
        longint      sum;
        longint      avg;
        longint      mono;
        int          n;
        t_out_item   r;
        if (!cfg_enabled) return;           // dropped, tags untouched
        ch = '{f.chan0, f.chan1, f.chan2, f.chan3, f.chan4, f.chan5, f.chan6, f.chan7};
        n = int'(cfg_chan_count);
        if (n == 0) n = 1;
        if (n > ADP_MAX_CHANNELS) n = ADP_MAX_CHANNELS;
        sum  = 0;
        mono = 0;
        if (!f.silent && cfg_format == FMT_INT16) begin
            for (int c = 0; c < n; c++) sum += longint'($signed(ch[c][15:0]));
            mono = sum / n;
        end else if (!f.silent && cfg_format == FMT_FLOAT32) begin
            for (int c = 0; c < n; c++) sum += fix24_of(ch[c]);
            avg = sum / n;
            if (avg > FIX_ONE) avg = FIX_ONE;
            if (avg < -FIX_ONE) avg = -FIX_ONE;
            mono = (avg * 32767) / FIX_ONE;
        end
        r.mono_sample   = mono[15:0];
        r.packet_number = packet_seq;
        r.slot          = slot_fill;
        r.last          = (int'(slot_fill) + 1 >= ADP_SAMPLES_PER_PACKET);
        r.rate_out      = cfg_rate;
        expected_samples.insert(expected_samples.size(), r);
        if (r.last) begin
            slot_fill  = '0;
            packet_seq = packet_seq + 16'd1;
        end else begin
            slot_fill = slot_fill + 8'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: bursts of random length, random gaps between them,
    // now and then long stretches with no gap at all. A stalled transfer
    // holds its payload; a gap only starts once the current one is taken.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_sample(i_in_item);
                frames_taken <= frames_taken + 1;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_frames.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_frames.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: begin
                                burst_left = $urandom_range(50, 200);
                                gap_left   = 0;
                            end
                            3: begin
                                burst_left = $urandom_range(1, 40);
                                gap_left   = $urandom_range(20, 60);
                            end
                            default: begin
                                burst_left = $urandom_range(1, 40);
                                gap_left   = $urandom_range(1, 8);
                            end
                        endcase
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Downstream stall pattern: modes that change at random
    // (free flowing, light, heavy, long runs), plus two long hold-offs
    // triggered part way through, so the job queue fills and the input
    // side stalls while the driver keeps offering frames.
    // ------------------------------------------------------------------
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_run_left  = 0;
    bit rx_run_stall = 1'b0;
    int hold_left    = 0;
    int holds_done   = 0;

    always @(posedge i_clk) begin : rx_pattern
        logic stall_next;
        stall_next = 1'b0;
        if (i_rst_n) begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(50, 400);
            end
            rx_mode_left--;
            if (hold_left == 0 && holds_done < 2 &&
                frames_taken >= (holds_done == 0 ? 500 : 1400)) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                case (rx_mode)
                    1: stall_next = ($urandom_range(0, 3) == 0);
                    2: stall_next = ($urandom_range(0, 3) != 0);
                    3: begin
                        if (rx_run_left == 0) begin
                            rx_run_stall = ~rx_run_stall;
                            rx_run_left  = $urandom_range(1, 20);
                        end
                        rx_run_left--;
                        stall_next = rx_run_stall;
                    end
                    default: stall_next = 1'b0;
                endcase
            end
        end
        i_out_stall <= stall_next;
    end

    // ------------------------------------------------------------------
    // Monitor: every output transfer is checked against the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : sample_monitor
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                $error("mono_sample: expected none, actual %0d", o_out_item.mono_sample);
                errors++;
            end else begin
                want = expected_samples.pop_front();
                check_field("mono_sample", want.mono_sample, o_out_item.mono_sample);
                check_field("packet_number", want.packet_number, o_out_item.packet_number);
                check_field("slot", want.slot, o_out_item.slot);
                check_field("last", want.last, o_out_item.last);
                check_field("rate_out", want.rate_out, o_out_item.rate_out);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in_item frame_pair(logic [31:0] a, logic [31:0] b, logic s);
        t_in_item f;
        f = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, 1'b0};
        f.chan0  = a;
        f.chan1  = b;
        f.silent = s;
        return f;
    endfunction

    function automatic t_in_item frame_fill(logic [31:0] v, logic s);
        return {v, v, v, v, v, v, v, v, s};
    endfunction

    // channel word shaped toward the format in use; some fully random
    function automatic logic [31:0] rand_chan(logic [1:0] fmt);
        logic [31:0] w;
        int          pick;
        w    = $urandom;
        pick = $urandom_range(0, 15);
        if (fmt == FMT_FLOAT32) begin
            if (pick < 10)       w[30:23] = 8'($urandom_range(104, 134));
            else if (pick == 10) w[30:23] = 8'h00;
            else if (pick == 11) w[30:23] = 8'hFF;
            else if (pick == 12) w[30:0]  = 31'h7F80_0000;
        end else if (fmt == FMT_INT16) begin
            if (pick == 0)      w[15:0] = 16'h7FFF;
            else if (pick == 1) w[15:0] = 16'h8000;
            else if (pick == 2) w[15:0] = 16'h0000;
        end
        return w;
    endfunction

    function automatic t_in_item rand_frame(logic [1:0] fmt);
        return {rand_chan(fmt), rand_chan(fmt), rand_chan(fmt), rand_chan(fmt),
                rand_chan(fmt), rand_chan(fmt), rand_chan(fmt), rand_chan(fmt),
                logic'($urandom_range(0, 9) == 0)};
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_CHANNEL_COUNT: cfg_chan_count = val[3:0];
            REG_SAMPLE_FORMAT: cfg_format     = val[1:0];
            REG_SAMPLE_RATE:   cfg_rate       = val;
            REG_ENABLED:       cfg_enabled    = val[0];
            default: ;
        endcase
    endtask

    // Wait for the block to go idle, then write all four registers.
    // Upper data bits are junk: the registers keep only their own width.
    task automatic configure(logic [3:0] cc, logic [1:0] fmt, logic [15:0] rate, logic en);
        while (pending_frames.size() > 0 || i_in_valid || expected_samples.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_CHANNEL_COUNT, {12'($urandom), cc});
        write_reg(REG_SAMPLE_FORMAT, {14'($urandom), fmt});
        write_reg(REG_SAMPLE_RATE, rate);
        write_reg(REG_ENABLED, {15'($urandom), en});
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [3:0]  cc;
        logic [1:0]  fmt;
        logic [15:0] rate;
        logic        en;
        int          nframes;
        int          waited;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // float32, two channels: unity, clamp, infinities, NaN, denormal,
        // negative zero, saturation at 128, tiniest step, largest normal, silence
        configure(4'd2, FMT_FLOAT32, 16'd48000, 1'b1);
        add_frame(frame_pair(32'h3F80_0000, 32'h3F80_0000, 1'b0));
        add_frame(frame_pair(32'hBF80_0000, 32'hBF80_0000, 1'b0));
        add_frame(frame_pair(32'h4000_0000, 32'h4000_0000, 1'b0));
        add_frame(frame_pair(32'h7F80_0000, 32'hFF80_0000, 1'b0));
        add_frame(frame_pair(32'h7FC0_0000, 32'h3F00_0000, 1'b0));
        add_frame(frame_pair(32'h0000_0001, 32'h8000_0000, 1'b0));
        add_frame(frame_pair(32'h4300_0000, 32'h3F80_0000, 1'b0));
        add_frame(frame_pair(32'h3380_0000, 32'h3380_0000, 1'b0));
        add_frame(frame_pair(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0));
        add_frame(frame_pair(32'h3F80_0000, 32'h3F80_0000, 1'b1));

        // int16, eight channels: both extremes, upper half ignored,
        // truncation toward zero on the divide, silence
        configure(4'd8, FMT_INT16, 16'hFFFF, 1'b1);
        add_frame(frame_fill(32'h0000_7FFF, 1'b0));
        add_frame(frame_fill(32'hFFFF_8000, 1'b0));
        add_frame({32'hABCD_FFF7, {7{32'h5A5A_0000}}, 1'b0});
        add_frame({32'h1234_0005, {7{32'hFFFF_0000}}, 1'b0});
        add_frame(frame_fill(32'h0000_7FFF, 1'b1));

        // one float channel just below unity, rate zero
        configure(4'd1, FMT_FLOAT32, 16'd0, 1'b1);
        add_frame(frame_pair(32'h3F7F_FFFF, 32'h0, 1'b0));
        add_frame(frame_pair(32'hBF7F_FFFF, 32'h0, 1'b0));

        // unsupported formats, zero and oversized channel counts, disabled
        configure(4'd3, FMT_UNSUPPORTED, 16'd44100, 1'b1);
        add_frame(rand_frame(FMT_FLOAT32));
        configure(4'd3, FMT_RESERVED, 16'd44100, 1'b1);
        add_frame(rand_frame(FMT_INT16));
        configure(4'd0, FMT_INT16, 16'd8000, 1'b1);
        add_frame(rand_frame(FMT_INT16));
        configure(4'd15, FMT_INT16, 16'd8000, 1'b1);
        add_frame(rand_frame(FMT_INT16));
        configure(4'd2, FMT_INT16, 16'd8000, 1'b0);
        add_frame(rand_frame(FMT_INT16));
        add_frame(rand_frame(FMT_INT16));

        // Random phases: the first few pin the register extremes, the rest
        // mostly use valid settings with an occasional odd one.
        for (int p = 0; p < PHASES; p++) begin
            cc   = 4'($urandom_range(1, 8));
            fmt  = 2'($urandom_range(0, 1));
            rate = 16'($urandom);
            en   = 1'b1;
            if ($urandom_range(0, 7) == 0) cc = 4'($urandom_range(9, 15));
            if ($urandom_range(0, 7) == 0) fmt = 2'($urandom_range(2, 3));
            case (p)
                0: begin cc = 4'd1;  fmt = FMT_INT16;   rate = 16'd0;     end
                1: begin cc = 4'd8;  fmt = FMT_FLOAT32; rate = 16'hFFFF;  end
                2: begin cc = 4'd0;  fmt = FMT_FLOAT32;                   end
                3: begin cc = 4'd15; fmt = FMT_INT16;                     end
                4: fmt = FMT_UNSUPPORTED;
                5: fmt = FMT_RESERVED;
                6: en  = 1'b0;
                default: ;
            endcase
            configure(cc, fmt, rate, en);
            nframes = en ? FRAMES_ENABLED : FRAMES_DROPPED;
            for (int i = 0; i < nframes; i++) begin
                // shape channel words toward the active format most of the time
                add_frame(rand_frame($urandom_range(0, 4) == 0 ? 2'($urandom) : fmt));
            end
        end

        // drain: all frames taken, then every prediction matched, then settle
        while (pending_frames.size() > 0 || i_in_valid) @(posedge i_clk);
        waited = 0;
        while (expected_samples.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_samples.size() > 0) begin
            $error("mono_sample: %0d expected results never arrived",
                   expected_samples.size());
            errors++;
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
